@@ hdl/fwt_pkg.sv @@
// fwt_pkg: shared types, codes and constants of the futex waiter table.
// Used by fwt_cell, fwt_chain and futex_waiter_table_unit.
package fwt_pkg;

    localparam int MAX_WAITERS_DEF = 32;
    localparam int PAGE_BYTES      = 4096;   // power of two, offsets are masked
    localparam int KEY_BITS        = 16;

    localparam logic [15:0] KEY_MASK = 16'((64'd1 << KEY_BITS) - 64'd1);
    localparam logic [11:0] OFF_MASK = 12'(PAGE_BYTES - 1);

    localparam logic [1:0] REQ_WAIT    = 2'd0;
    localparam logic [1:0] REQ_WAKE    = 2'd1;
    localparam logic [1:0] REQ_REQUEUE = 2'd2;
    localparam logic [1:0] REQ_PURGE   = 2'd3;

    localparam logic [1:0] ST_OK     = 2'd0;
    localparam logic [1:0] ST_PERM   = 2'd1;
    localparam logic [1:0] ST_FULL   = 2'd2;

    localparam logic KIND_REPORT = 1'b0;
    localparam logic KIND_DONE   = 1'b1;

    typedef struct packed {
        logic [1:0]  req_type;
        logic [15:0] page_key;
        logic [11:0] offset;
        logic [15:0] waiter_tag;
        logic [7:0]  wake_limit;
        logic [15:0] target_page_key;
        logic [11:0] target_offset;
        logic [7:0]  requeue_limit;
        logic        page_shared_file;
        logic        target_shared_file;
    } req_t;

    typedef struct packed {
        logic        result_kind;
        logic [15:0] woken_tag;
        logic [1:0]  status;
        logic [5:0]  done_count;
        logic        last;
    } rsp_t;

    typedef struct packed {
        logic [15:0] page;
        logic [11:0] off;
        logic [15:0] tag;
    } entry_t;

    typedef enum logic [1:0] {
        S_IDLE,
        S_SCAN,
        S_MOVE,
        S_DONE
    } state_t;

endpackage

@@ hdl/futex_waiter_table_unit.sv @@
// futex_waiter_table_unit: top level of the futex waiter table.
// Depends on fwt_pkg, fwt_chain, fwt_cell.
//
// Request channel req/req_valid/req_ready carries one req_t beat; result
// channel rsp/rsp_valid/rsp_ready carries rsp_t beats. Every request yields
// zero or more woken-waiter reports followed by one completion (last = 1).
// Waiters live in a chain of cells; a scan pops the head slot each cycle,
// drops it (woken or purged), sets it aside in a second chain (requeued) or
// pushes it back at the tail, so the table comes back in order.
// Wait and refused requests go straight to the completion in the result
// register. Wake, requeue and purge first scan the N waiters held, one slot
// per cycle while the result register is free, then move the M requeued
// waiters back to the main chain before the completion is loaded.
// Requests are taken one at a time, only while the unit is idle; the
// completion register does not block a new request.
// Reset empties the table at once (count to zero, no clearing pass).
// A stalled receiver holds the result register; the scan stops while a
// report cannot be handed over, and resumes when it is taken.
module futex_waiter_table_unit #(
    parameter int MAX_WAITERS = fwt_pkg::MAX_WAITERS_DEF
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          req_valid,
    output logic          req_ready,
    input  fwt_pkg::req_t req,
    output logic          rsp_valid,
    input  logic          rsp_ready,
    output fwt_pkg::rsp_t rsp
);

    localparam int IW = (MAX_WAITERS > 1) ? $clog2(MAX_WAITERS) : 1;
    localparam int CW = $clog2(MAX_WAITERS + 1);

    fwt_pkg::state_t state_reg, state_next;
    logic [CW-1:0]   count_reg, count_next;
    logic [CW-1:0]   rem_reg, rem_next;
    logic [CW-1:0]   woke_reg, woke_next;
    logic [CW-1:0]   moved_reg, moved_next;
    logic [CW-1:0]   done_reg, done_next;
    logic [1:0]      status_reg, status_next;
    fwt_pkg::req_t   cur_reg, cur_next;
    logic            out_valid_reg;
    fwt_pkg::rsp_t   out_reg;

    logic            accept, can_emit, emit;
    fwt_pkg::rsp_t   emit_data;
    logic            m_pop, m_push, q_pop, q_push;
    logic [IW-1:0]   m_idx, q_idx;
    fwt_pkg::entry_t m_data, q_data, m_head, q_head;
    logic            is_purge, hit;
    logic [15:0]     in_key;
    logic [11:0]     in_off;

    assign accept   = req_valid && req_ready;
    assign can_emit = !out_valid_reg || rsp_ready;
    assign is_purge = (cur_reg.req_type == fwt_pkg::REQ_PURGE);
    assign in_key   = req.page_key & fwt_pkg::KEY_MASK;
    assign in_off   = req.offset & fwt_pkg::OFF_MASK;
    assign hit      = (m_head.page == cur_reg.page_key) &&
                      (is_purge || (m_head.off == cur_reg.offset));

    // request as held for the scan, keys and offsets already reduced
    always_comb
    begin
        cur_next                 = req;
        cur_next.page_key        = in_key;
        cur_next.offset          = in_off;
        cur_next.target_page_key = req.target_page_key & fwt_pkg::KEY_MASK;
        cur_next.target_offset   = req.target_offset & fwt_pkg::OFF_MASK;
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            fwt_pkg::S_IDLE:
            begin
                if (accept)
                begin
                    if (req.req_type == fwt_pkg::REQ_WAIT ||
                        (req.req_type != fwt_pkg::REQ_PURGE &&
                         (req.page_shared_file ||
                          (req.req_type == fwt_pkg::REQ_REQUEUE &&
                           req.target_shared_file))))
                    begin
                        state_next = fwt_pkg::S_DONE;
                    end
                    else
                    begin
                        state_next = fwt_pkg::S_SCAN;
                    end
                end
            end
            fwt_pkg::S_SCAN:
            begin
                if (rem_reg == '0)
                begin
                    state_next = fwt_pkg::S_MOVE;
                end
            end
            fwt_pkg::S_MOVE:
            begin
                if (moved_reg == '0)
                begin
                    state_next = fwt_pkg::S_DONE;
                end
            end
            fwt_pkg::S_DONE:
            begin
                if (can_emit)
                begin
                    state_next = fwt_pkg::S_IDLE;
                end
            end
            default: state_next = fwt_pkg::S_IDLE;
        endcase
    end

    // datapath control
    always_comb
    begin
        req_ready   = (state_reg == fwt_pkg::S_IDLE);
        count_next  = count_reg;
        rem_next    = rem_reg;
        woke_next   = woke_reg;
        moved_next  = moved_reg;
        done_next   = done_reg;
        status_next = status_reg;
        m_pop = 1'b0; m_push = 1'b0; q_pop = 1'b0; q_push = 1'b0;
        m_idx  = count_reg[IW-1:0];
        q_idx  = moved_reg[IW-1:0];
        m_data = m_head;
        q_data = '{page: cur_reg.target_page_key, off: cur_reg.target_offset,
                   tag: m_head.tag};
        emit      = 1'b0;
        emit_data = '{result_kind: fwt_pkg::KIND_REPORT, woken_tag: m_head.tag,
                      status: fwt_pkg::ST_OK, done_count: 6'd0, last: 1'b0};
        unique case (state_reg)
            fwt_pkg::S_IDLE:
            begin
                rem_next    = count_reg;
                woke_next   = '0;
                moved_next  = '0;
                done_next   = '0;
                status_next = fwt_pkg::ST_OK;
                if (accept)
                begin
                    if (req.req_type == fwt_pkg::REQ_WAIT)
                    begin
                        if (req.page_shared_file)
                        begin
                            status_next = fwt_pkg::ST_PERM;
                        end
                        else if (count_reg >= CW'(MAX_WAITERS))
                        begin
                            status_next = fwt_pkg::ST_FULL;
                        end
                        else
                        begin
                            m_push     = 1'b1;
                            m_data     = '{page: in_key, off: in_off,
                                           tag: req.waiter_tag};
                            count_next = count_reg + 1'b1;
                        end
                    end
                    else if (req.req_type != fwt_pkg::REQ_PURGE &&
                             (req.page_shared_file ||
                              (req.req_type == fwt_pkg::REQ_REQUEUE &&
                               req.target_shared_file)))
                    begin
                        status_next = fwt_pkg::ST_PERM;
                    end
                end
            end
            fwt_pkg::S_SCAN:
            begin
                if (rem_reg != '0 && can_emit)
                begin
                    m_pop    = 1'b1;
                    rem_next = rem_reg - 1'b1;
                    if (hit && is_purge)
                    begin
                        count_next = count_reg - 1'b1;
                        done_next  = done_reg + 1'b1;
                    end
                    else if (hit && (8'(woke_reg) < cur_reg.wake_limit))
                    begin
                        emit       = 1'b1;
                        count_next = count_reg - 1'b1;
                        woke_next  = woke_reg + 1'b1;
                        done_next  = done_reg + 1'b1;
                    end
                    else if (hit && cur_reg.req_type == fwt_pkg::REQ_REQUEUE &&
                             (8'(moved_reg) < cur_reg.requeue_limit))
                    begin
                        q_push     = 1'b1;
                        count_next = count_reg - 1'b1;
                        moved_next = moved_reg + 1'b1;
                        done_next  = done_reg + 1'b1;
                    end
                    else
                    begin
                        // keep: back in at the tail, after the shift
                        m_push = 1'b1;
                        m_idx  = IW'(count_reg - 1'b1);
                    end
                end
            end
            fwt_pkg::S_MOVE:
            begin
                if (moved_reg != '0)
                begin
                    q_pop      = 1'b1;
                    m_push     = 1'b1;
                    m_data     = q_head;
                    count_next = count_reg + 1'b1;
                    moved_next = moved_reg - 1'b1;
                end
            end
            fwt_pkg::S_DONE:
            begin
                if (can_emit)
                begin
                    emit      = 1'b1;
                    emit_data = '{result_kind: fwt_pkg::KIND_DONE, woken_tag: 16'd0,
                                  status: status_reg, done_count: 6'(done_reg),
                                  last: 1'b1};
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= fwt_pkg::S_IDLE;
            count_reg     <= '0;
            rem_reg       <= '0;
            woke_reg      <= '0;
            moved_reg     <= '0;
            done_reg      <= '0;
            status_reg    <= fwt_pkg::ST_OK;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            count_reg  <= count_next;
            rem_reg    <= rem_next;
            woke_reg   <= woke_next;
            moved_reg  <= moved_next;
            done_reg   <= done_next;
            status_reg <= status_next;
            if (emit)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (rsp_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            cur_reg <= cur_next;
        end
        if (emit)
        begin
            out_reg <= emit_data;
        end
    end

    fwt_chain #(.DEPTH(MAX_WAITERS), .IW(IW)) u_main (
        .clk       (clk),
        .pop       (m_pop),
        .push      (m_push),
        .push_idx  (m_idx),
        .push_data (m_data),
        .head      (m_head)
    );

    fwt_chain #(.DEPTH(MAX_WAITERS), .IW(IW)) u_move (
        .clk       (clk),
        .pop       (q_pop),
        .push      (q_push),
        .push_idx  (q_idx),
        .push_data (q_data),
        .head      (q_head)
    );

    assign rsp_valid = out_valid_reg;
    assign rsp       = out_reg;

    a_count_max: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CW'(MAX_WAITERS))
        else $error("waiter count above table size");

    a_scan_stall: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == fwt_pkg::S_SCAN && rsp_valid && !rsp_ready |=> $stable(rem_reg))
        else $error("scan advanced while result stalled");

    a_done_last: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && rsp.result_kind == fwt_pkg::KIND_DONE |-> rsp.last)
        else $error("completion without last");

    a_moved_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg + moved_reg <= CW'(MAX_WAITERS) || state_reg != fwt_pkg::S_MOVE)
        else $error("requeued waiters overflow table");

endmodule

@@ hdl/fwt_cell.sv @@
// fwt_cell: one waiter slot of the chain.
// Depends on fwt_pkg (entry_t).
module fwt_cell (
    input  logic            clk,
    input  logic            shift,
    input  fwt_pkg::entry_t sh_data,
    input  logic            load,
    input  fwt_pkg::entry_t ld_data,
    output fwt_pkg::entry_t q
);

    fwt_pkg::entry_t q_reg;

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            q_reg <= ld_data;
        end
        else if (shift)
        begin
            q_reg <= sh_data;
        end
    end

    assign q = q_reg;

endmodule

@@ hdl/fwt_chain.sv @@
// fwt_chain: row of fwt_cell slots; pop shifts toward slot 0, push loads
// one slot by index (index counted after the shift). Depends on fwt_pkg.
module fwt_chain #(
    parameter int DEPTH = fwt_pkg::MAX_WAITERS_DEF,
    parameter int IW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic            clk,
    input  logic            pop,
    input  logic            push,
    input  logic [IW-1:0]   push_idx,
    input  fwt_pkg::entry_t push_data,
    output fwt_pkg::entry_t head
);

    fwt_pkg::entry_t q [DEPTH];

    for (genvar i = 0; i < DEPTH; i++)
    begin : g_cell
        fwt_pkg::entry_t nb;
        if (i == DEPTH - 1)
        begin : g_end
            assign nb = q[i];
        end
        else
        begin : g_mid
            assign nb = q[i+1];
        end

        fwt_cell u_cell (
            .clk     (clk),
            .shift   (pop),
            .sh_data (nb),
            .load    (push && (push_idx == IW'(i))),
            .ld_data (push_data),
            .q       (q[i])
        );
    end

    assign head = q[0];

endmodule
